// File: design/harq_tx_process_table_defines.svh
// Assertion helpers shared by the HARQ transmit process table.
`ifndef HARQ_TX_PROCESS_TABLE_DEFINES_SVH
`define HARQ_TX_PROCESS_TABLE_DEFINES_SVH

// Checked at every rising clock edge outside of reset.
`define HARQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define HARQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/harq_tpt_pkg.sv
`timescale 1ns / 1ps
package harq_tpt_pkg;

   localparam int NPROC = 8;
   localparam int IDX_W = (NPROC > 1) ? $clog2(NPROC) : 1;
   localparam int CNT_W = $clog2(NPROC + 1);
   localparam int LIM_W = 5;

   localparam int CMD_W    = 3;
   localparam int PID_W    = 4;
   localparam int FLOW_W   = 16;
   localparam int BEARER_W = 8;
   localparam int TICK_W   = 32;
   localparam int TXC_W    = 4;
   localparam int STAT_W   = 2;
   localparam int RETX_W   = 4;

   localparam logic [TXC_W-1:0] TXC_MAX = '1;

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_MAX_PROC    = 2'd0;
   localparam logic [1:0] REG_MAX_RETX    = 2'd1;
   localparam logic [1:0] REG_RETX_DELAY  = 2'd2;

   localparam logic [LIM_W-1:0]  MAX_PROC_RST    = 5'd8;
   localparam logic [RETX_W-1:0] MAX_RETX_RST    = 4'd4;
   localparam logic [TICK_W-1:0] RETX_DELAY_RST  = 32'd8;

   typedef enum logic [CMD_W-1:0] {
      CMD_NEW_UC  = 3'd0,
      CMD_NEW_MC  = 3'd1,
      CMD_RETX    = 3'd2,
      CMD_ACK     = 3'd3,
      CMD_SCAN    = 3'd4,
      CMD_SCAN_MC = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_BUSY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT,
      S_DONE
   } fsm_type;

   typedef enum logic [2:0] {
      TOP_NONE,
      TOP_CREATE_UC,
      TOP_CREATE_MC,
      TOP_RETX,
      TOP_FREE
   } tbl_op_type;

   typedef struct packed {
      tbl_op_type       op;
      logic [IDX_W-1:0] idx;
   } tbl_ctl_type;

   typedef struct packed {
      logic                mc;
      logic [TXC_W-1:0]    txc;
      logic [TICK_W-1:0]   tick;
      logic [FLOW_W-1:0]   flow;
      logic [BEARER_W-1:0] bearer;
   } tbl_rd_type;

endpackage

// File: design/harq_tpt_req_if.sv
`timescale 1ns / 1ps
interface harq_tpt_req_if import harq_tpt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [PID_W-1:0]    pid;
   logic [FLOW_W-1:0]   flow_id;
   logic [BEARER_W-1:0] bearer_id;
   logic                ack;
   logic [TICK_W-1:0]   now;

   modport source (output valid, cmd, pid, flow_id, bearer_id, ack, now, input ready);
   modport sink   (input valid, cmd, pid, flow_id, bearer_id, ack, now, output ready);
endinterface

// File: design/harq_tpt_rsp_if.sv
`timescale 1ns / 1ps
interface harq_tpt_rsp_if import harq_tpt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [PID_W-1:0]  free_pid;
   logic              free_valid;
   logic              flow_valid;
   logic [FLOW_W-1:0] flow_out;
   logic [PID_W-1:0]  flow_pid;
   logic              last;

   modport source (output valid, status, free_pid, free_valid, flow_valid, flow_out,
                   flow_pid, last, input ready);
   modport sink   (input valid, status, free_pid, free_valid, flow_valid, flow_out,
                   flow_pid, last, output ready);
endinterface

// File: design/harq_tx_process_table.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// req_bus   in   valid/ready   cmd, pid, flow_id, bearer_id, ack, now
// rsp_bus   out  valid/ready   status, free_pid, free_valid, flow_valid, flow_out,
//                              flow_pid, last
// csr_*     in   APB write     max_processes, max_retransmissions, retx_delay_ticks
//
// A command other than a scan is applied at the edge that accepts it; its single
// response is shown the next cycle.
// A scan walks the table with one timeout comparator, one entry per cycle, then shows
// one response per emitted process (or one for an empty scan), each held until it is
// taken, then returns to idle, where the next request can be taken.
// The block takes a new request only after the last response of the previous one.
// Reset is synchronous and clears the table flags and counts; no clearing pass.
`include "harq_tx_process_table_defines.svh"
module harq_tx_process_table import harq_tpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   harq_tpt_req_if.sink          req_bus,
   harq_tpt_rsp_if.source        rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [LIM_W-1:0]  max_proc_ff;
   logic [RETX_W-1:0] max_retx_ff;
   logic [TICK_W-1:0] delay_ff;
   logic              csr_wr;

   fsm_type             state_ff, state_in;
   logic                scan_mc_ff;
   logic [TICK_W-1:0]   now_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [NPROC-1:0]    emit_ff, emit_in;
   logic [STAT_W-1:0]   status_ff;
   logic [CNT_W-1:0]    bcount_ff;
   logic [BEARER_W-1:0] bearers_ff [NPROC];

   logic                req_fire, rsp_fire, is_scan;
   logic [LIM_W-1:0]    pid_lim, pid_ext;
   logic                in_range_uc, in_range_mc;
   logic [IDX_W-1:0]    rd_idx, pick;
   logic                pick_last;
   status_type          cmd_status;
   tbl_op_type          cmd_op;
   tbl_ctl_type         tbl_ctl;
   tbl_rd_type          rd;
   logic [NPROC-1:0]    valid_vec;
   logic                rd_valid, expired, seen, hit, scan_free, append;
   logic [PID_W-1:0]    free_pid;
   logic                free_valid;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_proc_ff <= MAX_PROC_RST;
         max_retx_ff <= MAX_RETX_RST;
         delay_ff    <= RETX_DELAY_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_MAX_PROC:   max_proc_ff <= csr_pwdata[LIM_W-1:0];
            REG_MAX_RETX:   max_retx_ff <= csr_pwdata[RETX_W-1:0];
            REG_RETX_DELAY: delay_ff    <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_MAX_PROC:   csr_prdata = 32'(max_proc_ff);
         REG_MAX_RETX:   csr_prdata = 32'(max_retx_ff);
         REG_RETX_DELAY: csr_prdata = delay_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // Request decode.
   assign req_fire    = req_bus.valid && req_bus.ready;
   assign rsp_fire    = rsp_bus.valid && rsp_bus.ready;
   assign is_scan     = (req_bus.cmd == CMD_SCAN) || (req_bus.cmd == CMD_SCAN_MC);
   assign pid_lim     = (max_proc_ff < LIM_W'(NPROC)) ? max_proc_ff : LIM_W'(NPROC);
   assign pid_ext     = LIM_W'(req_bus.pid);
   assign in_range_uc = (pid_ext < pid_lim);
   assign in_range_mc = (pid_ext < LIM_W'(NPROC));

   // Lowest pending emitted pid.
   always_comb begin
      pick = '0;
      for (int i = NPROC - 1; i >= 0; i--) begin
         if (emit_ff[i]) begin
            pick = IDX_W'(i);
         end
      end
   end
   assign pick_last = ((emit_ff & ~(NPROC'(1) << pick)) == '0);

   always_comb begin
      case (state_ff)
         S_SCAN:  rd_idx = idx_ff;
         S_EMIT:  rd_idx = pick;
         default: rd_idx = req_bus.pid[IDX_W-1:0];
      endcase
   end

   assign rd_valid = valid_vec[rd_idx];

   always_comb begin
      cmd_status = ST_OK;
      cmd_op     = TOP_NONE;
      case (req_bus.cmd)
         CMD_NEW_UC: begin
            if (!in_range_uc)   cmd_status = ST_MISSING;
            else if (rd_valid)  cmd_status = ST_BUSY;
            else                cmd_op     = TOP_CREATE_UC;
         end
         CMD_NEW_MC: begin
            if (!in_range_mc)   cmd_status = ST_MISSING;
            else if (rd_valid)  cmd_status = ST_BUSY;
            else                cmd_op     = TOP_CREATE_MC;
         end
         CMD_RETX: begin
            if (!in_range_mc || !rd_valid) cmd_status = ST_MISSING;
            else                           cmd_op     = TOP_RETX;
         end
         CMD_ACK: begin
            if (!in_range_mc || !rd_valid) cmd_status = ST_MISSING;
            else if (req_bus.ack)          cmd_op     = TOP_FREE;
         end
         CMD_SCAN, CMD_SCAN_MC: begin
         end
         default: cmd_status = ST_MISSING;
      endcase
   end

   // Shared timeout unit, one entry per scan cycle.
   harq_tpt_age u_age (
      .now       (now_ff),
      .last_tick (rd.tick),
      .delay     (delay_ff),
      .expired   (expired)
   );

   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < NPROC; i++) begin
         if (CNT_W'(i) < bcount_ff && bearers_ff[i] == rd.bearer) begin
            seen = 1'b1;
         end
      end
   end

   always_comb begin
      hit       = 1'b0;
      scan_free = 1'b0;
      append    = 1'b0;
      if (rd_valid) begin
         if (rd.txc >= max_retx_ff) begin
            scan_free = 1'b1;
         end else if (expired) begin
            if (!scan_mc_ff) begin
               if (!seen) begin
                  hit       = 1'b1;
                  append    = 1'b1;
                  scan_free = rd.mc;
               end
            end else if (rd.mc) begin
               hit       = 1'b1;
               scan_free = 1'b1;
            end
         end
      end
   end

   assign emit_in = emit_ff | (hit ? (NPROC'(1) << idx_ff) : '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = is_scan ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            if (idx_ff == IDX_W'(NPROC - 1)) state_in = (emit_in != '0) ? S_EMIT : S_DONE;
         end
         S_EMIT: begin
            if (rsp_fire && pick_last) state_in = S_IDLE;
         end
         S_DONE: begin
            if (rsp_fire) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_bus.ready = (state_ff == S_IDLE);
      rsp_bus.valid = (state_ff == S_EMIT) || (state_ff == S_DONE);
      tbl_ctl.idx   = rd_idx;
      tbl_ctl.op    = TOP_NONE;
      case (state_ff)
         S_IDLE:  if (req_fire) tbl_ctl.op = cmd_op;
         S_SCAN:  if (scan_free) tbl_ctl.op = TOP_FREE;
         default: tbl_ctl.op = TOP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         idx_ff     <= '0;
         emit_ff    <= '0;
         bcount_ff  <= '0;
         scan_mc_ff <= 1'b0;
         status_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  scan_mc_ff <= (req_bus.cmd == CMD_SCAN_MC);
                  status_ff  <= is_scan ? ST_OK : cmd_status;
                  idx_ff     <= '0;
                  emit_ff    <= '0;
                  if (is_scan) bcount_ff <= '0;
               end
            end
            S_SCAN: begin
               emit_ff <= emit_in;
               if (idx_ff != IDX_W'(NPROC - 1)) idx_ff <= idx_ff + IDX_W'(1);
               if (append && bcount_ff < CNT_W'(NPROC)) bcount_ff <= bcount_ff + CNT_W'(1);
            end
            S_EMIT: begin
               if (rsp_fire) emit_ff <= emit_ff & ~(NPROC'(1) << pick);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_fire) now_ff <= req_bus.now;
      if (state_ff == S_SCAN && append && bcount_ff < CNT_W'(NPROC)) begin
         bearers_ff[bcount_ff[IDX_W-1:0]] <= rd.bearer;
      end
   end

   harq_tpt_table u_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tbl_ctl),
      .wr_flow    (req_bus.flow_id),
      .wr_bearer  (req_bus.bearer_id),
      .wr_tick    (req_bus.now),
      .pid_lim    (pid_lim),
      .valid_vec  (valid_vec),
      .rd         (rd),
      .free_pid   (free_pid),
      .free_valid (free_valid)
   );

   // Response payload; the table does not change while responses are shown.
   assign rsp_bus.status     = (state_ff == S_EMIT) ? ST_OK : status_ff;
   assign rsp_bus.free_pid   = free_pid;
   assign rsp_bus.free_valid = free_valid;
   assign rsp_bus.flow_valid = (state_ff == S_EMIT);
   assign rsp_bus.flow_out   = (state_ff == S_EMIT) ? rd.flow : '0;
   assign rsp_bus.flow_pid   = (state_ff == S_EMIT) ? PID_W'(pick) : '0;
   assign rsp_bus.last       = (state_ff == S_EMIT) ? pick_last : 1'b1;

   `HARQ_ASSERT(a_no_overlap, clock, reset, !(req_bus.ready && rsp_bus.valid), "ready while busy")
   `HARQ_ASSERT(a_emit_pending, clock, reset, state_ff == S_EMIT |-> emit_ff != '0, "empty emit")
   `HARQ_ASSERT(a_last_idle, clock, reset, rsp_fire && rsp_bus.last |=> req_bus.ready, "not idle")
   `HARQ_ASSERT(a_bearer_cnt, clock, reset, bcount_ff <= CNT_W'(NPROC), "bearer list overflow")
   `HARQ_ASSERT(a_scan_quiet, clock, reset, state_ff == S_SCAN |-> tbl_ctl.op != TOP_RETX, "bad write")

endmodule

// File: design/harq_tpt_age.sv
`timescale 1ns / 1ps
module harq_tpt_age import harq_tpt_pkg::*; (
   input  logic [TICK_W-1:0] now,
   input  logic [TICK_W-1:0] last_tick,
   input  logic [TICK_W-1:0] delay,
   output logic              expired
);

   logic [TICK_W-1:0] elapsed;

   // Time wraps, so the elapsed count is taken modulo the tick width.
   assign elapsed = now - last_tick;
   assign expired = (elapsed > delay);

endmodule

// File: design/harq_tpt_table.sv
`timescale 1ns / 1ps
module harq_tpt_table import harq_tpt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  tbl_ctl_type         ctl,
   input  logic [FLOW_W-1:0]   wr_flow,
   input  logic [BEARER_W-1:0] wr_bearer,
   input  logic [TICK_W-1:0]   wr_tick,
   input  logic [LIM_W-1:0]    pid_lim,
   output logic [NPROC-1:0]    valid_vec,
   output tbl_rd_type          rd,
   output logic [PID_W-1:0]    free_pid,
   output logic                free_valid
);

   logic [NPROC-1:0]    valid_ff, valid_in;
   logic [NPROC-1:0]    mc_ff, mc_in;
   logic [TXC_W-1:0]    txc_ff [NPROC];
   logic [TXC_W-1:0]    txc_in;
   logic [TICK_W-1:0]   tick_ff [NPROC];
   logic [FLOW_W-1:0]   flow_ff [NPROC];
   logic [BEARER_W-1:0] bearer_ff [NPROC];

   always_comb begin
      valid_in = valid_ff;
      mc_in    = mc_ff;
      txc_in   = txc_ff[ctl.idx];
      case (ctl.op)
         TOP_CREATE_UC, TOP_CREATE_MC: begin
            valid_in[ctl.idx] = 1'b1;
            mc_in[ctl.idx]    = (ctl.op == TOP_CREATE_MC);
            txc_in            = TXC_W'(1);
         end
         TOP_RETX: begin
            if (txc_ff[ctl.idx] != TXC_MAX) begin
               txc_in = txc_ff[ctl.idx] + TXC_W'(1);
            end
         end
         TOP_FREE: begin
            valid_in[ctl.idx] = 1'b0;
            mc_in[ctl.idx]    = 1'b0;
            txc_in            = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mc_ff    <= '0;
         for (int i = 0; i < NPROC; i++) begin
            txc_ff[i] <= '0;
         end
      end else begin
         valid_ff         <= valid_in;
         mc_ff            <= mc_in;
         txc_ff[ctl.idx]  <= txc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == TOP_CREATE_UC || ctl.op == TOP_CREATE_MC) begin
         flow_ff[ctl.idx]   <= wr_flow;
         bearer_ff[ctl.idx] <= wr_bearer;
      end
      if (ctl.op == TOP_CREATE_UC || ctl.op == TOP_CREATE_MC || ctl.op == TOP_RETX) begin
         tick_ff[ctl.idx] <= wr_tick;
      end
   end

   assign valid_vec = valid_ff;
   assign rd.mc     = mc_ff[ctl.idx];
   assign rd.txc    = txc_ff[ctl.idx];
   assign rd.tick   = tick_ff[ctl.idx];
   assign rd.flow   = flow_ff[ctl.idx];
   assign rd.bearer = bearer_ff[ctl.idx];

   // Lowest unused pid below the limit in force.
   always_comb begin
      free_pid   = '0;
      free_valid = 1'b0;
      for (int i = NPROC - 1; i >= 0; i--) begin
         if (LIM_W'(i) < pid_lim && !valid_ff[i]) begin
            free_pid   = PID_W'(i);
            free_valid = 1'b1;
         end
      end
   end

endmodule

// File: sim/harq_tx_process_table_tb.sv
`timescale 1ns / 1ps
module harq_tx_process_table_tb;
   import harq_tpt_pkg::*;

   // Codes 6 and 7 have no operation behind them and must be refused.
   localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

   localparam int RAND_PHASES     = 5;
   localparam int PHASE_ITEMS     = 56;
   localparam int LONG_HOLD       = 80;
   localparam int SETTLE_CYCLES   = 20;
   // A full scan stalled on every one of its responses stays far below this.
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int DIR_ROWS        = 24;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [PID_W-1:0]    pid;
      logic [FLOW_W-1:0]   flow_id;
      logic [BEARER_W-1:0] bearer_id;
      logic                ack;
      logic [TICK_W-1:0]   now;
   } harq_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PID_W-1:0]  free_pid;
      logic              free_valid;
      logic              flow_valid;
      logic [FLOW_W-1:0] flow_out;
      logic [PID_W-1:0]  flow_pid;
      logic              last;
   } harq_rsp_type;

   typedef struct packed {
      harq_req_type      req;
      logic              typed;
      logic [STAT_W-1:0] status;
      logic [PID_W-1:0]  free_pid;
      logic              free_valid;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   harq_tpt_req_if req_bus ();
   harq_tpt_rsp_if rsp_bus ();

   harq_tx_process_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the process table and its registers.
   logic                tbl_live   [NPROC];
   logic                tbl_mc     [NPROC];
   logic [TXC_W-1:0]    tbl_txc    [NPROC];
   logic [TICK_W-1:0]   tbl_tick   [NPROC];
   logic [FLOW_W-1:0]   tbl_flow   [NPROC];
   logic [BEARER_W-1:0] tbl_bearer [NPROC];
   logic [LIM_W-1:0]    cfg_max_proc = MAX_PROC_RST;
   logic [RETX_W-1:0]   cfg_max_retx = MAX_RETX_RST;
   logic [TICK_W-1:0]   cfg_delay    = RETX_DELAY_RST;

   harq_rsp_type step_rsp    [$];
   harq_rsp_type pending_rsp [$];
   harq_rsp_type want;
   int           mismatches  = 0;
   int           idle_odds   = 5;
   bit           long_hold   = 1'b0;
   int           stall_cycles = 0;
   logic [31:0]  now_tick;

   logic [LIM_W-1:0]  phase_max_proc [RAND_PHASES] = '{5'd16, 5'd1, 5'd5, 5'd8, 5'd16};
   logic [RETX_W-1:0] phase_max_retx [RAND_PHASES] = '{4'd15, 4'd0, 4'd3, 4'd2, 4'd4};
   logic [TICK_W-1:0] phase_delay    [RAND_PHASES] =
      '{32'hFFFF_FFFF, 32'd0, 32'd6, 32'd3, 32'd10};
   int                phase_idle     [RAND_PHASES] = '{4, 8, 3, 6, 0};

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{'{CMD_ACK,     4'd0,  16'h0000, 8'h00, 1'b1, 32'd0},        1'b1, ST_MISSING, 4'd0, 1'b1},
      '{'{CMD_RETX,    4'd15, 16'h0000, 8'h00, 1'b0, 32'd0},        1'b1, ST_MISSING, 4'd0, 1'b1},
      '{'{CMD_RSVD_6,  4'd0,  16'h0000, 8'h00, 1'b0, 32'd0},        1'b1, ST_MISSING, 4'd0, 1'b1},
      '{'{CMD_RSVD_7,  4'd15, 16'hFFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF}, 1'b1, ST_MISSING, 4'd0, 1'b1},
      '{'{CMD_SCAN,    4'd0,  16'h0000, 8'h00, 1'b0, 32'd0},        1'b0, ST_OK,      4'd0, 1'b0},
      '{'{CMD_NEW_UC,  4'd8,  16'h0001, 8'h01, 1'b0, 32'd0},        1'b1, ST_MISSING, 4'd0, 1'b1},
      '{'{CMD_NEW_UC,  4'd15, 16'h0001, 8'h01, 1'b0, 32'd0},        1'b1, ST_MISSING, 4'd0, 1'b1},
      '{'{CMD_NEW_UC,  4'd0,  16'hFFFF, 8'hFF, 1'b0, 32'd0},        1'b1, ST_OK,      4'd1, 1'b1},
      '{'{CMD_NEW_UC,  4'd0,  16'h0000, 8'h00, 1'b0, 32'd5},        1'b1, ST_BUSY,    4'd1, 1'b1},
      '{'{CMD_NEW_MC,  4'd1,  16'h0000, 8'hFF, 1'b0, 32'd0},        1'b1, ST_OK,      4'd2, 1'b1},
      '{'{CMD_NEW_MC,  4'd9,  16'h5555, 8'h10, 1'b0, 32'd0},        1'b1, ST_MISSING, 4'd2, 1'b1},
      '{'{CMD_NEW_MC,  4'd1,  16'h5555, 8'h10, 1'b0, 32'd0},        1'b1, ST_BUSY,    4'd2, 1'b1},
      '{'{CMD_NEW_UC,  4'd7,  16'h1234, 8'h01, 1'b0, 32'hFFFF_FFF0}, 1'b1, ST_OK,      4'd2, 1'b1},
      '{'{CMD_NEW_UC,  4'd2,  16'hAAAA, 8'hFF, 1'b0, 32'd0},        1'b1, ST_OK,      4'd3, 1'b1},
      '{'{CMD_RETX,    4'd7,  16'h0000, 8'h00, 1'b0, 32'hFFFF_FFF8}, 1'b1, ST_OK,      4'd3, 1'b1},
      '{'{CMD_ACK,     4'd2,  16'h0000, 8'h00, 1'b0, 32'd1},        1'b1, ST_OK,      4'd3, 1'b1},
      '{'{CMD_RETX,    4'd5,  16'h0000, 8'h00, 1'b0, 32'd1},        1'b1, ST_MISSING, 4'd3, 1'b1},
      '{'{CMD_SCAN,    4'd0,  16'h0000, 8'h00, 1'b0, 32'd9},        1'b0, ST_OK,      4'd0, 1'b0},
      '{'{CMD_SCAN_MC, 4'd0,  16'h0000, 8'h00, 1'b0, 32'd100},      1'b0, ST_OK,      4'd0, 1'b0},
      '{'{CMD_RETX,    4'd0,  16'h0000, 8'h00, 1'b0, 32'd100},      1'b0, ST_OK,      4'd0, 1'b0},
      '{'{CMD_RETX,    4'd0,  16'h0000, 8'h00, 1'b0, 32'd101},      1'b0, ST_OK,      4'd0, 1'b0},
      '{'{CMD_RETX,    4'd0,  16'h0000, 8'h00, 1'b0, 32'd102},      1'b0, ST_OK,      4'd0, 1'b0},
      '{'{CMD_SCAN,    4'd0,  16'h0000, 8'h00, 1'b0, 32'd200},      1'b0, ST_OK,      4'd0, 1'b0},
      '{'{CMD_ACK,     4'd7,  16'h0000, 8'h00, 1'b1, 32'd201},      1'b0, ST_OK,      4'd0, 1'b0}
   };

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned usable_pids();
      return (cfg_max_proc < NPROC) ? cfg_max_proc : NPROC;
   endfunction

   function automatic bit lowest_free(output logic [PID_W-1:0] fp);
      fp = '0;
      for (int p = 0; p < usable_pids(); p++) begin
         if (!tbl_live[p]) begin
            fp = PID_W'(p);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void drop_entry(int p);
      tbl_live[p] = 1'b0;
      tbl_mc[p]   = 1'b0;
      tbl_txc[p]  = '0;
   endfunction

   // Applies one request to the shadow table and leaves its responses in step_rsp.
   function automatic void predict_responses(input harq_req_type r);
      logic [BEARER_W-1:0] chosen [$];
      logic [STAT_W-1:0]   st;
      logic [TICK_W-1:0]   age;
      logic [IDX_W-1:0]    idx;
      logic [PID_W-1:0]    fp;
      harq_rsp_type        one;
      bit                  dup;
      bit                  fv;
      step_rsp.delete();
      idx = r.pid[IDX_W-1:0];
      if (r.cmd == CMD_SCAN || r.cmd == CMD_SCAN_MC) begin
         for (int p = 0; p < NPROC; p++) begin
            if (!tbl_live[p]) continue;
            age = r.now - tbl_tick[p];
            if (tbl_txc[p] >= cfg_max_retx) begin
               drop_entry(p);
            end else if (age > cfg_delay) begin
               if (r.cmd == CMD_SCAN) begin
                  dup = 1'b0;
                  foreach (chosen[i]) if (chosen[i] == tbl_bearer[p]) dup = 1'b1;
                  if (dup) continue;
                  chosen.insert(chosen.size(), tbl_bearer[p]);
               end else if (!tbl_mc[p]) begin
                  continue;
               end
               one            = '0;
               one.flow_valid = 1'b1;
               one.flow_out   = tbl_flow[p];
               one.flow_pid   = PID_W'(p);
               step_rsp.insert(step_rsp.size(), one);
               if (tbl_mc[p]) drop_entry(p);
            end
         end
         if (step_rsp.size() == 0) step_rsp.insert(0, '0);
      end else begin
         st = ST_OK;
         case (r.cmd)
            CMD_NEW_UC, CMD_NEW_MC: begin
               if ((r.cmd == CMD_NEW_UC && r.pid >= usable_pids()) || r.pid >= NPROC) begin
                  st = ST_MISSING;
               end else if (tbl_live[idx]) begin
                  st = ST_BUSY;
               end else begin
                  tbl_live[idx]   = 1'b1;
                  tbl_mc[idx]     = (r.cmd == CMD_NEW_MC);
                  tbl_txc[idx]    = TXC_W'(1);
                  tbl_tick[idx]   = r.now;
                  tbl_flow[idx]   = r.flow_id;
                  tbl_bearer[idx] = r.bearer_id;
               end
            end
            CMD_RETX: begin
               if (r.pid >= NPROC) begin
                  st = ST_MISSING;
               end else if (!tbl_live[idx]) begin
                  st = ST_MISSING;
               end else begin
                  if (tbl_txc[idx] != TXC_MAX) tbl_txc[idx] = tbl_txc[idx] + TXC_W'(1);
                  tbl_tick[idx] = r.now;
               end
            end
            CMD_ACK: begin
               if (r.pid >= NPROC) begin
                  st = ST_MISSING;
               end else if (!tbl_live[idx]) begin
                  st = ST_MISSING;
               end else if (r.ack) begin
                  drop_entry(int'(idx));
               end
            end
            default: st = ST_MISSING;
         endcase
         one        = '0;
         one.status = st;
         step_rsp.insert(step_rsp.size(), one);
      end
      fv = lowest_free(fp);
      foreach (step_rsp[k]) begin
         step_rsp[k].free_pid   = fp;
         step_rsp[k].free_valid = fv;
      end
      step_rsp[step_rsp.size() - 1].last = 1'b1;
   endfunction

   // Mostly well-formed traffic: new processes on free pids, retransmits and acks on
   // live ones, scans as time moves on; the rest is out-of-range pids, stray ticks and reserved codes.
   function automatic harq_req_type random_request();
      harq_req_type     r;
      int unsigned      live [$];
      int unsigned      pick;
      logic [PID_W-1:0] fp;
      for (int p = 0; p < NPROC; p++) if (tbl_live[p]) live.insert(live.size(), p);
      now_tick    = now_tick + 32'($urandom_range(0, 15));
      r.now       = ($urandom_range(0, 15) == 0) ? $urandom : now_tick;
      r.flow_id   = FLOW_W'($urandom);
      r.bearer_id = ($urandom_range(0, 3) == 0) ? BEARER_W'($urandom)
                                               : BEARER_W'($urandom_range(0, 3));
      r.ack       = 1'($urandom);
      r.pid       = ($urandom_range(0, 4) == 0) ? PID_W'($urandom)
                                               : PID_W'($urandom_range(0, NPROC - 1));
      pick = $urandom_range(0, 99);
      if (pick < 37) begin
         r.cmd = (pick < 25) ? CMD_NEW_UC : CMD_NEW_MC;
         if ($urandom_range(0, 1) && lowest_free(fp)) r.pid = fp;
      end else if (pick < 72) begin
         r.cmd = (pick < 57) ? CMD_RETX : CMD_ACK;
         if (live.size() != 0 && $urandom_range(0, 4) != 0)
            r.pid = PID_W'(live[$urandom_range(0, live.size() - 1)]);
      end else if (pick < 88) begin
         r.cmd = CMD_SCAN;
      end else if (pick < 96) begin
         r.cmd = CMD_SCAN_MC;
      end else begin
         r.cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
      end
      return r;
   endfunction

   task automatic send_request(input harq_req_type r, input logic typed,
                               input harq_rsp_type fixed);
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= r.cmd;
      req_bus.pid       <= r.pid;
      req_bus.flow_id   <= r.flow_id;
      req_bus.bearer_id <= r.bearer_id;
      req_bus.ack       <= r.ack;
      req_bus.now       <= r.now;
      do @(posedge clock); while (!req_bus.ready);
      predict_responses(r);
      if (typed) pending_rsp.insert(pending_rsp.size(), fixed);
      else foreach (step_rsp[k]) pending_rsp.insert(pending_rsp.size(), step_rsp[k]);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (reg_idx)
         REG_MAX_PROC:   cfg_max_proc = value[LIM_W-1:0];
         REG_MAX_RETX:   cfg_max_retx = value[RETX_W-1:0];
         REG_RETX_DELAY: cfg_delay    = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none, actual %0h",
                     $time, rsp_bus.flow_out);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("free_pid", 32'(want.free_pid), 32'(rsp_bus.free_pid));
            check_field("free_valid", 32'(want.free_valid), 32'(rsp_bus.free_valid));
            check_field("flow_valid", 32'(want.flow_valid), 32'(rsp_bus.flow_valid));
            check_field("flow_out", 32'(want.flow_out), 32'(rsp_bus.flow_out));
            check_field("flow_pid", 32'(want.flow_pid), 32'(rsp_bus.flow_pid));
            check_field("last", 32'(want.last), 32'(rsp_bus.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: no request or response moved for %0d cycles", $time, stall_cycles);
         $display("status: fail");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off that backs the block up.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold = 1'b0;
         end else if (idle_odds != 0 && $urandom_range(0, 2 * idle_odds) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = '0;
      req_bus.pid       = '0;
      req_bus.flow_id   = '0;
      req_bus.bearer_id = '0;
      req_bus.ack       = 1'b0;
      req_bus.now       = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      now_tick          = $urandom;
      for (int p = 0; p < NPROC; p++) drop_entry(p);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].req, dir_rows[i].typed,
                      '{dir_rows[i].status, dir_rows[i].free_pid, dir_rows[i].free_valid,
                        1'b0, 16'h0000, 4'h0, 1'b1});
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain_responses();
         csr_write(REG_MAX_PROC, 32'(phase_max_proc[ph]));
         csr_write(REG_MAX_RETX, 32'(phase_max_retx[ph]));
         csr_write(REG_RETX_DELAY, phase_delay[ph]);
         idle_odds = phase_idle[ph];
         if (ph == 2) long_hold = 1'b1;
         if (ph == 0) begin
            // Retransmit one process past the 4-bit count so that it has to saturate,
            // then scan: a saturated count is still dropped at the limit of 15.
            send_request('{CMD_ACK, 4'd3, 16'h0000, 8'h00, 1'b1, now_tick}, 1'b0, '0);
            send_request('{CMD_NEW_UC, 4'd3, 16'hBEEF, 8'h33, 1'b0, now_tick}, 1'b0, '0);
            repeat (17) send_request('{CMD_RETX, 4'd3, 16'h0000, 8'h00, 1'b0, now_tick},
                                     1'b0, '0);
            send_request('{CMD_SCAN, 4'd0, 16'h0000, 8'h00, 1'b0, now_tick}, 1'b0, '0);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request(), 1'b0, '0);
      end

      drain_responses();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/harq_tpt_pkg.sv
design/harq_tpt_req_if.sv
design/harq_tpt_rsp_if.sv
design/harq_tpt_age.sv
design/harq_tpt_table.sv
design/harq_tx_process_table.sv
sim/harq_tx_process_table_tb.sv
